### rtl/core/serial_line_editor_assert.svh
// Assertion macros shared by the serial line editor RTL.
`ifndef SERIAL_LINE_EDITOR_ASSERT_SVH
`define SERIAL_LINE_EDITOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SLE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/sle_pkg.sv
// Shared types and constants of the serial line editor.
`timescale 1ns / 1ps

package sle_pkg;

   localparam int LINE_CAPACITY_DEF = 1024;

   localparam int REQ_TYPE_W = 2;
   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 10;
   localparam int KIND_W     = 2;
   localparam int LEN_W      = 10;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_BYTE  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ECHO   = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_CANCEL = 2'd2,
      KIND_READ   = 2'd3
   } rsp_kind_type;

   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_ETX   = 8'h03;
   localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_ESC   = 8'h1b;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7f;

endpackage

### rtl/core/sle_channels.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface sle_req_if;
   logic                          valid;
   logic                          ready;
   logic [sle_pkg::REQ_TYPE_W-1:0] req_type;
   logic [sle_pkg::BYTE_W-1:0]     rx_byte;
   logic [sle_pkg::INDEX_W-1:0]    read_index;

   modport source (output valid, output req_type, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input req_type, input rx_byte, input read_index,
                   output ready);
endinterface

interface sle_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [sle_pkg::KIND_W-1:0] kind;
   logic [sle_pkg::BYTE_W-1:0] data_byte;
   logic [sle_pkg::LEN_W-1:0]  line_length;
   logic                       last;

   modport source (output valid, output kind, output data_byte, output line_length,
                   output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input line_length,
                   input last, output ready);
endinterface

### rtl/core/serial_line_editor.sv
// Serial line editor: builds one command line from received terminal bytes.
//
// Usage:
//  - req_chan carries one request per transfer: a received byte, a read of
//    one line store entry, or a clear that arms the next line.
//  - rsp_chan carries the results: echo bytes, line complete, line
//    cancelled and read data; last marks the final result of a request.
//  - A request that yields a result loads the job stage at its transfer;
//    the output register then takes the result from there and raises
//    rsp_chan.valid, so a result passes through both before it transfers.
//  - An echoed byte yields one result, DEL three (backspace, space,
//    backspace) and a silent request none. The output register sets the
//    pace: one result per clock while the receiver takes them.
//  - The line store is a single-port-write, one-read synchronous memory of
//    LINE_CAPACITY bytes; its contents are undefined after reset.
//  - Reset clears the character count and all valid flags; no clearing pass.
//  - When the receiver stalls, the output register holds its result, the
//    job stage holds the next one, and req_chan.ready drops behind them.
`timescale 1ns / 1ps
`include "serial_line_editor_assert.svh"

module serial_line_editor #(
   parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   sle_req_if.sink          req_chan,
   sle_rsp_if.source        rsp_chan
);

   localparam int ADDR_W = $clog2(LINE_CAPACITY);
   localparam int CNT_W  = ADDR_W;
   localparam int WIDE_W = ((ADDR_W > sle_pkg::INDEX_W) ? ADDR_W : sle_pkg::INDEX_W) + 1;

   localparam logic [CNT_W:0]    ROOM_LIMIT = (CNT_W + 1)'(LINE_CAPACITY - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(LINE_CAPACITY - 1);
   localparam logic [WIDE_W-1:0] CAP_WIDE   = WIDE_W'(LINE_CAPACITY);

   // Line store and its registered read port.
   logic [sle_pkg::BYTE_W-1:0] store_mem [LINE_CAPACITY];
   logic [sle_pkg::BYTE_W-1:0] mem_rdata_ff;
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_waddr;
   logic [sle_pkg::BYTE_W-1:0] mem_wdata;
   logic                       mem_re;
   logic [ADDR_W-1:0]          mem_raddr;

   // Character count.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Job stage: one decoded request waiting to emit its results.
   logic                        s1_valid_ff, s1_valid_in;
   sle_pkg::rsp_kind_type       s1_kind_ff, s1_kind_in;
   logic [sle_pkg::BYTE_W-1:0]  s1_data_ff, s1_data_in;
   logic [sle_pkg::LEN_W-1:0]   s1_len_ff, s1_len_in;
   logic                        s1_del_ff, s1_del_in;
   logic                        s1_read_ff, s1_read_in;
   logic                        s1_range_ff, s1_range_in;
   logic [1:0]                  s1_step_ff, s1_step_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   sle_pkg::rsp_kind_type       rsp_kind_ff, rsp_kind_in;
   logic [sle_pkg::BYTE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [sle_pkg::LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        req_accept;
   logic                        rsp_load;
   logic                        emit_last;
   logic [sle_pkg::BYTE_W-1:0]  emit_data;
   logic                        emits;
   logic [WIDE_W-1:0]           idx_wide;
   logic [WIDE_W-1:0]           len_wide;
   logic [sle_pkg::BYTE_W-1:0]  rx;
   logic                        printable;

   // Output side: a result moves from the job stage into the output register
   // whenever the register is empty or its result is taken this cycle.
   assign rsp_load = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      if (s1_del_ff) begin
         emit_last = (s1_step_ff == 2'd2);
         emit_data = (s1_step_ff == 2'd1) ? sle_pkg::CHAR_SPACE : sle_pkg::CHAR_BS;
      end else if (s1_read_ff) begin
         emit_last = 1'b1;
         emit_data = s1_range_ff ? mem_rdata_ff : sle_pkg::CHAR_NUL;
      end else begin
         emit_last = 1'b1;
         emit_data = s1_data_ff;
      end
   end

   // Take a new request while the job stage is free or hands its last result on.
   assign req_chan.ready = !s1_valid_ff || (rsp_load && emit_last);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rx        = req_chan.rx_byte;
   assign printable = (rx >= sle_pkg::CHAR_SPACE) && !rx[sle_pkg::BYTE_W-1];
   assign idx_wide  = WIDE_W'(req_chan.read_index);

   // Decode the request against the current count; update count and store.
   always_comb begin
      count_in    = count_ff;
      emits       = 1'b0;
      s1_kind_in  = sle_pkg::KIND_ECHO;
      s1_data_in  = sle_pkg::CHAR_NUL;
      s1_del_in   = 1'b0;
      s1_read_in  = 1'b0;
      s1_range_in = idx_wide < CAP_WIDE;
      mem_we      = 1'b0;
      mem_waddr   = count_ff;
      mem_wdata   = rx;
      mem_re      = 1'b0;
      mem_raddr   = idx_wide[ADDR_W-1:0];
      if (req_accept) begin
         case (sle_pkg::req_kind_type'(req_chan.req_type))
            sle_pkg::REQ_READ: begin
               mem_re     = 1'b1;
               emits      = 1'b1;
               s1_kind_in = sle_pkg::KIND_READ;
               s1_read_in = 1'b1;
            end
            sle_pkg::REQ_CLEAR: begin
               count_in = '0;
            end
            sle_pkg::REQ_BYTE: begin
               if (rx == sle_pkg::CHAR_DEL) begin
                  if (count_ff != '0) begin
                     count_in  = count_ff - 1'b1;
                     emits     = 1'b1;
                     s1_del_in = 1'b1;
                  end
               end else if (printable) begin
                  if ({1'b0, count_ff} < ROOM_LIMIT) begin
                     mem_we     = 1'b1;
                     count_in   = count_ff + 1'b1;
                     emits      = 1'b1;
                     s1_data_in = rx;
                  end
               end else if (rx == sle_pkg::CHAR_CR) begin
                  // Terminate the line in the store; the count stays.
                  mem_we     = 1'b1;
                  mem_wdata  = sle_pkg::CHAR_NUL;
                  emits      = 1'b1;
                  s1_kind_in = sle_pkg::KIND_DONE;
               end else if (rx == sle_pkg::CHAR_ESC || rx == sle_pkg::CHAR_ETX) begin
                  count_in   = '0;
                  emits      = 1'b1;
                  s1_kind_in = sle_pkg::KIND_CANCEL;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign len_wide  = WIDE_W'(count_in);
   assign s1_len_in = len_wide[sle_pkg::LEN_W-1:0];

   // Job stage next state: load on a transfer with results, advance the DEL
   // step on each emitted result, drop the job after its last result.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_step_in  = s1_step_ff;
      if (rsp_load) begin
         if (emit_last) begin
            s1_valid_in = 1'b0;
         end else begin
            s1_step_in = s1_step_ff + 1'b1;
         end
      end
      if (req_accept) begin
         s1_valid_in = emits;
         s1_step_in  = 2'd0;
      end
   end

   // Output register next state.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = s1_kind_ff;
         rsp_data_in  = emit_data;
         rsp_len_in   = s1_len_ff;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_step_ff  <= s1_step_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
      if (req_accept) begin
         s1_kind_ff  <= s1_kind_in;
         s1_data_ff  <= s1_data_in;
         s1_len_ff   <= s1_len_in;
         s1_del_ff   <= s1_del_in;
         s1_read_ff  <= s1_read_in;
         s1_range_ff <= s1_range_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.data_byte   = rsp_data_ff;
   assign rsp_chan.line_length = rsp_len_ff;
   assign rsp_chan.last        = rsp_last_ff;

   `SLE_ASSERT_SAME(a_count_range, 1'b1, count_ff <= CNT_MAX,
                    "character count beyond line capacity")
   `SLE_ASSERT_SAME(a_del_is_echo, s1_valid_ff && s1_del_ff,
                    s1_kind_ff == sle_pkg::KIND_ECHO, "DEL job with non-echo kind")
   `SLE_ASSERT_SAME(a_del_blocks_input, s1_valid_ff && s1_del_ff && s1_step_ff != 2'd2,
                    !req_chan.ready, "request taken in the middle of a DEL sequence")
   `SLE_ASSERT_NEXT(a_read_loads_job,
                    req_accept && req_chan.req_type == sle_pkg::REQ_READ,
                    s1_valid_ff && s1_read_ff, "read request did not load a read job")

endmodule

### verif/serial_line_editor_test.sv
// Self-checking testbench for the serial line editor with echo.
`timescale 1ns / 1ps

module serial_line_editor_test;

   localparam int LINE_CAP = sle_pkg::LINE_CAPACITY_DEF;
   localparam int BYTE_W   = sle_pkg::BYTE_W;
   localparam int INDEX_W  = sle_pkg::INDEX_W;
   localparam int LEN_W    = sle_pkg::LEN_W;

   // One request as queued for the driver; hold_for_drain keeps it back until
   // every awaited response has arrived.
   typedef struct {
      sle_pkg::req_kind_type kind;
      logic [BYTE_W-1:0]     rx;
      logic [INDEX_W-1:0]    idx;
      bit                    hold_for_drain;
   } line_req_type;

   typedef struct {
      sle_pkg::rsp_kind_type kind;
      logic [BYTE_W-1:0]     data;
      logic [LEN_W-1:0]      len;
      logic                  last;
   } line_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sle_req_if req_bus ();
   sle_rsp_if rsp_bus ();

   serial_line_editor u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #4 clock = ~clock;

   // Pending requests, responses still owed, and the shadow of the line.
   line_req_type      pending[$];
   line_rsp_type      awaited_rsp[$];
   line_req_type      on_bus;
   logic [BYTE_W-1:0] line_shadow [0:LINE_CAP-1];
   bit                slot_written [0:LINE_CAP-1];
   int                written_slots[$];
   int unsigned       char_total;
   int                idle_pct = 20;
   int                stim_count;
   int                error_count;

   // Queue one response for the current line state.
   function automatic void owe_rsp(sle_pkg::rsp_kind_type k, logic [BYTE_W-1:0] d,
                                   logic fin);
      line_rsp_type r;
      r.kind = k;
      r.data = d;
      r.len  = char_total[LEN_W-1:0];
      r.last = fin;
      awaited_rsp.push_back(r);
   endfunction

   function automatic void store_char(int unsigned pos, logic [BYTE_W-1:0] c);
      line_shadow[pos] = c;
      if (!slot_written[pos]) begin
         slot_written[pos] = 1'b1;
         written_slots.push_back(pos);
      end
   endfunction

   // Apply one accepted request to the line shadow and record what it owes.
   function automatic void apply_line_edit(line_req_type r);
      case (r.kind)
         sle_pkg::REQ_READ: begin
            owe_rsp(sle_pkg::KIND_READ, line_shadow[r.idx], 1'b1);
         end
         sle_pkg::REQ_CLEAR: begin
            char_total = 0;
         end
         sle_pkg::REQ_BYTE: begin
            if (r.rx == sle_pkg::CHAR_DEL) begin
               // Rub out the last character: backspace, space, backspace.
               if (char_total > 0) begin
                  char_total--;
                  owe_rsp(sle_pkg::KIND_ECHO, sle_pkg::CHAR_BS, 1'b0);
                  owe_rsp(sle_pkg::KIND_ECHO, sle_pkg::CHAR_SPACE, 1'b0);
                  owe_rsp(sle_pkg::KIND_ECHO, sle_pkg::CHAR_BS, 1'b1);
               end
            end else if (r.rx >= sle_pkg::CHAR_SPACE && !r.rx[7]) begin
               // Printable: keep one slot free for the terminator.
               if (char_total < LINE_CAP - 1) begin
                  store_char(char_total, r.rx);
                  char_total++;
                  owe_rsp(sle_pkg::KIND_ECHO, r.rx, 1'b1);
               end
            end else if (r.rx == sle_pkg::CHAR_CR) begin
               if (char_total < LINE_CAP) store_char(char_total, sle_pkg::CHAR_NUL);
               owe_rsp(sle_pkg::KIND_DONE, sle_pkg::CHAR_NUL, 1'b1);
            end else if (r.rx == sle_pkg::CHAR_ESC || r.rx == sle_pkg::CHAR_ETX) begin
               char_total = 0;
               owe_rsp(sle_pkg::KIND_CANCEL, sle_pkg::CHAR_NUL, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   // Driver: advance to the next pending request once the current one has
   // transferred, idling at random and holding drain-marked requests back.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) apply_line_edit(on_bus);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                !(pending[0].hold_for_drain && awaited_rsp.size() != 0)) begin
               on_bus = pending.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.req_type   <= on_bus.kind;
               req_bus.rx_byte    <= on_bus.rx;
               req_bus.read_index <= on_bus.idx;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, check each transfer against the oldest
   // awaited response field by field.
   always @(posedge clock) begin
      line_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsp.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected response: kind %0d data %02h len %0d last %0d",
                           rsp_bus.kind, rsp_bus.data_byte, rsp_bus.line_length,
                           rsp_bus.last);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_bus.kind !== want.kind || rsp_bus.data_byte !== want.data ||
                   rsp_bus.line_length !== want.len || rsp_bus.last !== want.last) begin
                  error_count++;
                  if (error_count <= 10)
                     $display(
                        "mismatch exp/act: kind %0d/%0d data %02h/%02h len %0d/%0d last %0d/%0d",
                        want.kind, rsp_bus.kind, want.data, rsp_bus.data_byte,
                        want.len, rsp_bus.line_length, want.last, rsp_bus.last);
               end
            end
         end
      end
   end

   // Queue a request, throttled so reads can rely on the line shadow: an entry
   // marked written there stays written for every later request.
   task automatic post(sle_pkg::req_kind_type k, logic [BYTE_W-1:0] b,
                       logic [INDEX_W-1:0] i, bit drain = 1'b0);
      line_req_type r;
      r.kind = k;
      r.rx = b;
      r.idx = i;
      r.hold_for_drain = drain;
      while (pending.size() >= 4) @(posedge clock);
      pending.push_back(r);
      // Tally only requests the editor acts on.
      if (!(k == sle_pkg::REQ_NONE || (k == sle_pkg::REQ_BYTE && b != sle_pkg::CHAR_DEL &&
            (b[7] || (b < sle_pkg::CHAR_SPACE && b != sle_pkg::CHAR_CR &&
                      b != sle_pkg::CHAR_ESC && b != sle_pkg::CHAR_ETX)))))
         stim_count++;
   endtask

   task automatic post_byte(logic [BYTE_W-1:0] b);
      post(sle_pkg::REQ_BYTE, b, INDEX_W'($urandom_range(0, LINE_CAP - 1)));
   endtask

   function automatic logic [BYTE_W-1:0] printable();
      return BYTE_W'($urandom_range(sle_pkg::CHAR_SPACE, sle_pkg::CHAR_DEL - 1));
   endfunction

   // Read a slot already written; fall back to a printable on a blank store.
   task automatic post_read(bit drain = 1'b0);
      if (written_slots.size() == 0) begin
         post_byte(printable());
      end else begin
         post(sle_pkg::REQ_READ, BYTE_W'($urandom_range(0, 255)),
              INDEX_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]), drain);
      end
   endtask

   // A typed line with random content, mostly ended properly.
   task automatic edit_session();
      int n;
      int sel;
      if ($urandom_range(0, 3) == 0)
         post(sle_pkg::REQ_CLEAR, BYTE_W'($urandom), INDEX_W'($urandom));
      n = $urandom_range(0, 16);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) post_byte(sle_pkg::CHAR_DEL);
         else post_byte(printable());
      end
      sel = $urandom_range(0, 9);
      if (sel <= 6) begin
         post_byte(sle_pkg::CHAR_CR);
         if (sel == 0) post_byte(sle_pkg::CHAR_CR);
      end else if (sel == 7) begin
         post_byte(sle_pkg::CHAR_ESC);
      end else if (sel == 8) begin
         post_byte(sle_pkg::CHAR_ETX);
      end
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) post_read();
   endtask

   // Noise: any request kind with any byte.
   task automatic line_noise();
      sle_pkg::req_kind_type k;
      k = sle_pkg::req_kind_type'($urandom_range(0, 3));
      if (k == sle_pkg::REQ_READ) post_read();
      else post(k, BYTE_W'($urandom_range(0, 255)),
                INDEX_W'($urandom_range(0, LINE_CAP - 1)));
   endtask

   initial begin
      int target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored bytes, DEL on an empty line, printable extremes,
      // rub-out, repeated carriage return, cancel by escape and ctrl-C,
      // clear, unused request kind and reads of known slots.
      post_byte(sle_pkg::CHAR_DEL);
      post_byte(8'h00);
      post_byte(8'hff);
      post_byte(8'h80);
      post_byte(sle_pkg::CHAR_SPACE);
      post_byte(8'h7e);
      post_byte(8'h41);
      post_byte(sle_pkg::CHAR_DEL);
      post_byte(sle_pkg::CHAR_CR);
      post_byte(sle_pkg::CHAR_CR);
      post(sle_pkg::REQ_READ, 8'hff, 10'd0, 1'b1);
      post(sle_pkg::REQ_READ, 8'h00, 10'd2);
      post_byte(sle_pkg::CHAR_ESC);
      post_byte(8'h5a);
      post_byte(sle_pkg::CHAR_ETX);
      post(sle_pkg::REQ_NONE, 8'hff, 10'h3ff);
      post_byte(8'h71);
      post_byte(8'h72);
      post(sle_pkg::REQ_CLEAR, 8'h0d, 10'h3ff);
      post(sle_pkg::REQ_READ, 8'h7f, 10'd1);
      post_byte(8'h0a);
      post_byte(8'h1f);
      post_byte(8'h09);

      // Random lines with some noise mixed in.
      target = stim_count + 200;
      while (stim_count < target) begin
         if ($urandom_range(0, 4) == 0) line_noise();
         else edit_session();
      end

      // A long stretch with no idling on either side, closed by a read that
      // waits until every awaited response has come.
      idle_pct = 0;
      target = stim_count + 120;
      while (stim_count < target) begin
         if ($urandom_range(0, 4) == 0) line_noise();
         else edit_session();
      end
      post_read(1'b1);
      idle_pct = 20;

      // More random lines, reading back across the store.
      target = stim_count + 130;
      while (stim_count < target) begin
         if ($urandom_range(0, 4) == 0) line_noise();
         else edit_session();
      end

      // Drain, then let the pipeline idle on so that stray responses show up.
      while (pending.size() != 0 || req_bus.valid || awaited_rsp.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0 && awaited_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule
